>>> rtl/core/cesd_pkg.sv
// Shared types and constants for the C escape sequence decoder.
// Used by the front decoder, the group queue, the back serializer and the top level.
package cesd_pkg;

    // Results that one input byte can cause at most
    localparam int MAX_RESULTS = 5;
    localparam int RES_CNT_W   = 3;

    // Bit positions inside the result tuser byte
    localparam int USER_VALID_BIT = 0;
    localparam int USER_EOS_BIT   = 1;
    localparam int USER_OVF_BIT   = 2;
    localparam int USER_W         = 8;

    // Group of results caused by one input transaction
    typedef struct packed {
        logic [RES_CNT_W-1:0]             cnt;
        logic [MAX_RESULTS-1:0][7:0]      data;
        logic [MAX_RESULTS-1:0]           vld;
        logic [MAX_RESULTS-1:0]           ovf;
        logic                             eos;
    } group_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/core/cesd_front.sv
// Front decoder: accepts escaped bytes, tracks the pending escape and builds result groups.
// Depends on cesd_pkg for group_t and q_status_t.
module cesd_front
    import cesd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // last_in
    input  q_status_t  q_status,
    output logic       push,
    output group_t     push_group
);

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_OCT    = 3'd2;
    localparam logic [2:0] MODE_HEX    = 3'd3;
    localparam logic [2:0] MODE_UNI    = 3'd4;

    logic [2:0]       mode_reg, mode_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [15:0]      acc_reg, acc_next;
    logic [2:0][7:0]  buf_reg, buf_next;
    logic [4:0]       hex_res;
    logic             do_plain;
    logic             accept;
    group_t           res;

    // Append one result to a group
    function automatic group_t emit(group_t r, logic [7:0] b, logic v, logic o);
        group_t g;
        g = r;
        if (g.cnt < RES_CNT_W'(MAX_RESULTS)) begin
            g.data[g.cnt] = b;
            g.vld[g.cnt]  = v;
            g.ovf[g.cnt]  = o;
            g.cnt         = g.cnt + 1'b1;
        end
        return g;
    endfunction

    // Hex digit check: bit 4 flags a digit, low nibble is its value
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] h;
        h = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h = {1'b1, c[3:0] + 4'd9};
        end
        return h;
    endfunction

    // Encode a 16-bit code point as one to three UTF-8 bytes
    function automatic group_t emit_utf8(group_t r, logic [15:0] code);
        group_t g;
        g = r;
        if (code < 16'h0080) begin
            g = emit(g, code[7:0], 1'b1, 1'b0);
        end else if (code < 16'h0800) begin
            g = emit(g, 8'hc0 | {3'b0, code[10:6]}, 1'b1, 1'b0);
            g = emit(g, 8'h80 | {2'b0, code[5:0]}, 1'b1, 1'b0);
        end else begin
            g = emit(g, 8'he0 | {4'b0, code[15:12]}, 1'b1, 1'b0);
            g = emit(g, 8'h80 | {2'b0, code[11:6]}, 1'b1, 1'b0);
            g = emit(g, 8'h80 | {2'b0, code[5:0]}, 1'b1, 1'b0);
        end
        return g;
    endfunction

    // Emit what a pending escape stands for
    function automatic group_t finish(group_t r, logic [2:0] mode, logic [2:0] cnt,
                                      logic [15:0] acc, logic [2:0][7:0] digits);
        group_t g;
        g = r;
        case (mode)
            MODE_OCT: begin
                if (cnt == 3'd0)          g = emit(g, 8'h30, 1'b1, 1'b0);
                else if (acc > 16'd255)   g = emit(g, 8'h00, 1'b0, 1'b1);
                else                      g = emit(g, acc[7:0], 1'b1, 1'b0);
            end
            MODE_HEX: begin
                if (cnt == 3'd0) g = emit(g, 8'h78, 1'b1, 1'b0);
                else             g = emit(g, acc[7:0], 1'b1, 1'b0);
            end
            MODE_UNI: begin
                g = emit(g, 8'h75, 1'b1, 1'b0);
                for (int k = 0; k < 3; k++) begin
                    if (3'(k) < cnt) g = emit(g, digits[k], 1'b1, 1'b0);
                end
            end
            default: begin
                g = r;
            end
        endcase
        return g;
    endfunction

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // Decode one byte against the pending escape
    always_comb begin
        res       = '0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        buf_next  = buf_reg;
        do_plain  = 1'b0;
        hex_res   = hex_val(s_tdata);
        case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_NORMAL;
                cnt_next  = 3'd0;
                acc_next  = 16'd0;
                case (s_tdata)
                    8'h30:   mode_next = MODE_OCT;
                    8'h78:   mode_next = MODE_HEX;
                    8'h75:   mode_next = MODE_UNI;
                    8'h61:   res = emit(res, 8'h07, 1'b1, 1'b0);
                    8'h62:   res = emit(res, 8'h08, 1'b1, 1'b0);
                    8'h66:   res = emit(res, 8'h0c, 1'b1, 1'b0);
                    8'h6e:   res = emit(res, 8'h0a, 1'b1, 1'b0);
                    8'h72:   res = emit(res, 8'h0d, 1'b1, 1'b0);
                    8'h74:   res = emit(res, 8'h09, 1'b1, 1'b0);
                    8'h76:   res = emit(res, 8'h0b, 1'b1, 1'b0);
                    default: res = emit(res, s_tdata, 1'b1, 1'b0);
                endcase
            end
            MODE_OCT: begin
                if (s_tdata >= 8'h30 && s_tdata <= 8'h37) begin
                    acc_next = {acc_reg[12:0], s_tdata[2:0]};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_next >= 3'd3) begin
                        res       = finish(res, MODE_OCT, cnt_next, acc_next, buf_next);
                        mode_next = MODE_NORMAL;
                        cnt_next  = 3'd0;
                        acc_next  = 16'd0;
                    end
                end else begin
                    res       = finish(res, mode_reg, cnt_reg, acc_reg, buf_reg);
                    mode_next = MODE_NORMAL;
                    cnt_next  = 3'd0;
                    acc_next  = 16'd0;
                    do_plain  = 1'b1;
                end
            end
            MODE_HEX: begin
                if (hex_res[4]) begin
                    acc_next = {acc_reg[11:0], hex_res[3:0]};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_next >= 3'd2) begin
                        res       = finish(res, MODE_HEX, cnt_next, acc_next, buf_next);
                        mode_next = MODE_NORMAL;
                        cnt_next  = 3'd0;
                        acc_next  = 16'd0;
                    end
                end else begin
                    res       = finish(res, mode_reg, cnt_reg, acc_reg, buf_reg);
                    mode_next = MODE_NORMAL;
                    cnt_next  = 3'd0;
                    acc_next  = 16'd0;
                    do_plain  = 1'b1;
                end
            end
            MODE_UNI: begin
                if (hex_res[4]) begin
                    if (cnt_reg < 3'd3) buf_next[cnt_reg[1:0]] = s_tdata;
                    acc_next = {acc_reg[11:0], hex_res[3:0]};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_next >= 3'd4) begin
                        res       = emit_utf8(res, acc_next);
                        mode_next = MODE_NORMAL;
                        cnt_next  = 3'd0;
                        acc_next  = 16'd0;
                    end
                end else begin
                    res       = finish(res, mode_reg, cnt_reg, acc_reg, buf_reg);
                    mode_next = MODE_NORMAL;
                    cnt_next  = 3'd0;
                    acc_next  = 16'd0;
                    do_plain  = 1'b1;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
                cnt_next  = 3'd0;
                acc_next  = 16'd0;
                do_plain  = 1'b1;
            end
        endcase

        // Handle an ordinary byte: backslash opens an escape
        if (do_plain) begin
            if (s_tdata == 8'h5c) mode_next = MODE_ESC;
            else                  res = emit(res, s_tdata, 1'b1, 1'b0);
        end

        // Flush at end of string, with a bare end marker if nothing came out
        if (s_tlast) begin
            res       = finish(res, mode_next, cnt_next, acc_next, buf_next);
            mode_next = MODE_NORMAL;
            cnt_next  = 3'd0;
            acc_next  = 16'd0;
            if (res.cnt == '0) res = emit(res, 8'h00, 1'b0, 1'b0);
            res.eos = 1'b1;
        end
    end

    assign push       = accept && (res.cnt != '0);
    assign push_group = res;

    // Advance decode state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= 3'd0;
            acc_reg  <= 16'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

    // Digit buffer holds payload only
    always_ff @(posedge aclk) begin
        if (accept) begin
            buf_reg <= buf_next;
        end
    end

endmodule

>>> rtl/core/cesd_queue.sv
// Short queue of result groups between the front decoder and the back serializer.
// Depends on cesd_pkg for group_t and q_status_t.
module cesd_queue
    import cesd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  group_t    push_group,
    input  logic      pop,
    output group_t    head_group,
    output q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t              slots_reg [DEPTH];
    logic [PTR_W-1:0]    wptr_reg, rptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_group     = slots_reg[rptr_reg];

    // Store pushed groups
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wptr_reg] <= push_group;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/cesd_back.sv
// Back serializer: takes one result group at a time and drives one result per transaction.
// Depends on cesd_pkg for group_t, q_status_t and the tuser bit positions.
module cesd_back
    import cesd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  group_t            head_group,
    input  q_status_t         q_status,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte
    output logic [USER_W-1:0] m_tuser,   // out_valid, end_of_string, octal_overflow, zero fill
    output logic              m_tlast    // last_of_run
);

    group_t               hold_reg;
    logic                 hvalid_reg;
    logic [RES_CNT_W-1:0] idx_reg;
    logic                 final_res;
    logic                 m_accept;
    logic                 load;

    assign final_res = (idx_reg == hold_reg.cnt - 1'b1);
    assign m_accept  = hvalid_reg && m_tready;
    assign load      = !hvalid_reg || (m_accept && final_res);
    assign pop       = load && !q_status.empty;

    // Drive the current result from the held group
    always_comb begin
        m_tuser                 = '0;
        m_tvalid                = hvalid_reg;
        m_tdata                 = hold_reg.data[idx_reg];
        m_tlast                 = final_res;
        m_tuser[USER_VALID_BIT] = hold_reg.vld[idx_reg];
        m_tuser[USER_EOS_BIT]   = hold_reg.eos && final_res;
        m_tuser[USER_OVF_BIT]   = hold_reg.ovf[idx_reg];
    end

    // Step through the group, then load the next one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hvalid_reg <= 1'b0;
            idx_reg    <= '0;
        end else begin
            if (m_accept && !final_res) begin
                idx_reg <= idx_reg + 1'b1;
            end else if (load) begin
                hvalid_reg <= !q_status.empty;
                idx_reg    <= '0;
            end
        end
    end

    // Hold group payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            hold_reg <= head_group;
        end
    end

endmodule

>>> rtl/core/c_escape_sequence_decoder_core.sv
// Top level of the C escape sequence decoder.
// Depends on cesd_pkg, cesd_front, cesd_queue and cesd_back.
//
// Usage:
//   Input channel s_*: one raw byte of an escaped string per transaction, s_tlast on the
//   final byte of the string. Output channel m_*: one decoded result per transaction;
//   m_tuser carries out_valid, end_of_string and octal_overflow, m_tlast marks the last
//   result caused by one input byte.
//   A byte that causes results is decoded into the group queue, then loaded into the
//   serializer hold register, from which its first result is shown on m_*.
//   Throughput: one input byte per cycle while the group queue has room; the output
//   side moves one result per cycle while m_tready is high and a group is held, so a byte
//   that causes N results (1 to 5) holds the output for N transfers and the queue absorbs
//   the difference. Bytes that only open or extend an escape cause no result.
//   Reset (aresetn low, synchronous) returns the decoder to normal mode and empties
//   the queue and the serializer; the digit buffer keeps stale payload.
//   When the receiver stalls, the held result stays on m_* and input continues to be
//   taken until QUEUE_DEPTH groups wait; s_tready then drops.
module c_escape_sequence_decoder_core
    import cesd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // in_byte
    input  logic              s_tlast,   // last_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte
    output logic [USER_W-1:0] m_tuser,   // out_valid, end_of_string, octal_overflow, zero fill
    output logic              m_tlast    // last_of_run
);

    q_status_t q_status;
    group_t    push_group;
    group_t    head_group;
    logic      push;
    logic      pop;

    cesd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_group (push_group)
    );

    cesd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head_group (head_group),
        .q_status   (q_status)
    );

    cesd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_group (head_group),
        .q_status   (q_status),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // Never push a group into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) !(push && q_status.full))
        else $error("group pushed into full queue");

    // End of string only on the last result of a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_EOS_BIT] |-> m_tlast)
        else $error("end of string without last of run");

    // A result without a byte carries zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[USER_VALID_BIT] |-> m_tdata == 8'h00)
        else $error("non-byte result with nonzero data");

    // Overflow suppresses the byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_OVF_BIT] |-> !m_tuser[USER_VALID_BIT])
        else $error("octal overflow result marked valid");

endmodule

>>> sim/c_escape_sequence_decoder_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the C escape sequence decoder core: directed strings, then
// random escape sequences, with and without source and sink stalls. Depends on cesd_pkg.
module c_escape_sequence_decoder_core_test;
    import cesd_pkg::*;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam int         RUN_ITEMS = 150;

    // Decoder modes of the predictor
    typedef enum logic [2:0] {
        DEC_NORMAL = 3'd0,
        DEC_ESC    = 3'd1,
        DEC_OCT    = 3'd2,
        DEC_HEX    = 3'd3,
        DEC_UNI    = 3'd4
    } dec_mode_t;

    // One decoded result as seen on the m_* channel
    typedef struct packed {
        logic [7:0] data;
        logic       vld;
        logic       eos;
        logic       ovf;
        logic       run_last;
    } dec_result_t;

    // One raw input byte with its end-of-string flag
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } raw_byte_t;

    // Directed row: input byte, end flag, and a typed-in result where one is obvious
    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic        typed;
        dec_result_t want;
    } stim_row_t;

    localparam stim_row_t DIRECTED [24] = '{
        '{"A",       1'b0, 1'b1, '{"A",   1'b1, 1'b0, 1'b0, 1'b1}},
        '{8'h00,     1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{8'hFF,     1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{BACKSLASH, 1'b0, 1'b0, '0},
        '{"n",       1'b0, 1'b1, '{8'h0A, 1'b1, 1'b0, 1'b0, 1'b1}},
        // octal 777 overflows
        '{BACKSLASH, 1'b0, 1'b0, '0},
        '{"0",       1'b0, 1'b0, '0},
        '{"7",       1'b0, 1'b0, '0},
        '{"7",       1'b0, 1'b0, '0},
        '{"7",       1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        // two hex digits in mixed case
        '{BACKSLASH, 1'b0, 1'b0, '0},
        '{"x",       1'b0, 1'b0, '0},
        '{"f",       1'b0, 1'b0, '0},
        '{"F",       1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}},
        // three-byte UTF-8
        '{BACKSLASH, 1'b0, 1'b0, '0},
        '{"u",       1'b0, 1'b0, '0},
        '{"2",       1'b0, 1'b0, '0},
        '{"0",       1'b0, 1'b0, '0},
        '{"a",       1'b0, 1'b0, '0},
        '{"c",       1'b0, 1'b0, '0},
        // short unicode escape cut by end of string
        '{BACKSLASH, 1'b0, 1'b0, '0},
        '{"u",       1'b0, 1'b0, '0},
        '{"4",       1'b1, 1'b0, '0},
        // trailing lone backslash leaves a bare end marker
        '{BACKSLASH, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1}}
    };

    localparam logic [7:0] CTRL_LETTERS [7] = '{"a", "b", "f", "n", "r", "t", "v"};

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic [USER_W-1:0] m_tuser;
    logic              m_tlast;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches    = 0;
    dec_result_t due_results [$];
    raw_byte_t   random_bytes [$];

    // Predictor state
    dec_mode_t   dec_mode  = DEC_NORMAL;
    logic [2:0]  dec_cnt   = '0;
    logic [15:0] dec_acc   = '0;
    logic [7:0]  dec_digits [3];
    dec_result_t step_out [$];

    c_escape_sequence_decoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- queue helpers

    // Append one raw byte to the random string
    function automatic void add_raw(input logic [7:0] ch, input logic fin);
        raw_byte_t r;
        r.ch  = ch;
        r.fin = fin;
        random_bytes.insert(random_bytes.size(), r);
    endfunction

    // Append one expected result to the scoreboard
    function automatic void add_due(input dec_result_t r);
        due_results.insert(due_results.size(), r);
    endfunction

    // ---------------------------------------------------------------- predictor

    function automatic void put(input logic [7:0] b, input logic v, input logic o);
        dec_result_t r;
        r = '{data: b, vld: v, eos: 1'b0, ovf: o, run_last: 1'b0};
        step_out.insert(step_out.size(), r);
    endfunction

    // {is_hex, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'd0;
    endfunction

    function automatic void clear_escape();
        dec_mode = DEC_NORMAL;
        dec_cnt  = '0;
        dec_acc  = '0;
    endfunction

    function automatic void put_utf8(input logic [15:0] code);
        if (code < 16'h0080) begin
            put(code[7:0], 1'b1, 1'b0);
        end else if (code < 16'h0800) begin
            put(8'hC0 | 8'(code >> 6), 1'b1, 1'b0);
            put(8'h80 | 8'(code & 16'h3F), 1'b1, 1'b0);
        end else begin
            put(8'hE0 | 8'(code >> 12), 1'b1, 1'b0);
            put(8'h80 | 8'((code >> 6) & 16'h3F), 1'b1, 1'b0);
            put(8'h80 | 8'(code & 16'h3F), 1'b1, 1'b0);
        end
    endfunction

    // Emit what a pending escape stands for, then drop back to normal mode
    function automatic void flush_escape();
        int n;
        case (dec_mode)
            DEC_OCT: begin
                if (dec_cnt == 0) put("0", 1'b1, 1'b0);
                else if (dec_acc > 16'd255) put(8'h00, 1'b0, 1'b1);
                else put(dec_acc[7:0], 1'b1, 1'b0);
            end
            DEC_HEX: begin
                if (dec_cnt == 0) put("x", 1'b1, 1'b0);
                else put(dec_acc[7:0], 1'b1, 1'b0);
            end
            DEC_UNI: begin
                put("u", 1'b1, 1'b0);
                n = (dec_cnt > 3) ? 3 : int'(dec_cnt);
                for (int k = 0; k < n; k++) put(dec_digits[k], 1'b1, 1'b0);
            end
            default: ;
        endcase
        clear_escape();
    endfunction

    function automatic void plain_char(input logic [7:0] c);
        if (c == BACKSLASH) dec_mode = DEC_ESC;
        else put(c, 1'b1, 1'b0);
    endfunction

    function automatic void escaped_char(input logic [7:0] c);
        clear_escape();
        case (c)
            "0": dec_mode = DEC_OCT;
            "x": dec_mode = DEC_HEX;
            "u": dec_mode = DEC_UNI;
            "a": put(8'h07, 1'b1, 1'b0);
            "b": put(8'h08, 1'b1, 1'b0);
            "f": put(8'h0C, 1'b1, 1'b0);
            "n": put(8'h0A, 1'b1, 1'b0);
            "r": put(8'h0D, 1'b1, 1'b0);
            "t": put(8'h09, 1'b1, 1'b0);
            "v": put(8'h0B, 1'b1, 1'b0);
            default: put(c, 1'b1, 1'b0);
        endcase
    endfunction

    // Decode one raw byte into step_out, tagging end flags on the last result
    function automatic void unescape_byte(input logic [7:0] c, input logic fin);
        logic [4:0] hv;
        step_out.delete();
        hv = hex_value(c);
        case (dec_mode)
            DEC_ESC: escaped_char(c);
            DEC_OCT: begin
                if (c >= "0" && c <= "7") begin
                    dec_acc = dec_acc * 16'd8 + 16'(c - "0");
                    dec_cnt++;
                    if (dec_cnt >= 3) flush_escape();
                end else begin
                    flush_escape();
                    plain_char(c);
                end
            end
            DEC_HEX: begin
                if (hv[4]) begin
                    dec_acc = dec_acc * 16'd16 + 16'(hv[3:0]);
                    dec_cnt++;
                    if (dec_cnt >= 2) flush_escape();
                end else begin
                    flush_escape();
                    plain_char(c);
                end
            end
            DEC_UNI: begin
                if (hv[4]) begin
                    if (dec_cnt < 3) dec_digits[dec_cnt] = c;
                    dec_acc = dec_acc * 16'd16 + 16'(hv[3:0]);
                    dec_cnt++;
                    if (dec_cnt >= 4) begin
                        put_utf8(dec_acc);
                        clear_escape();
                    end
                end else begin
                    flush_escape();
                    plain_char(c);
                end
            end
            default: begin
                clear_escape();
                plain_char(c);
            end
        endcase
        if (fin) begin
            flush_escape();
            if (step_out.size() == 0) put(8'h00, 1'b0, 1'b0);
        end
        if (step_out.size() != 0) begin
            step_out[$].run_last = 1'b1;
            step_out[$].eos      = fin;
        end
    endfunction

    // ---------------------------------------------------------------- random strings

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return "0" + 8'(v);
        return ($urandom_range(1) ? "a" : "A") + 8'(v) - 8'd10;
    endfunction

    // Append one escape sequence or plain byte with random content
    function automatic void add_sequence();
        int          n;
        logic [15:0] code;
        case ($urandom_range(9))
            0: add_raw(8'($urandom_range(255)), 1'b0);
            1: add_raw(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
            2: begin
                add_raw(BACKSLASH, 1'b0);
                add_raw(CTRL_LETTERS[$urandom_range(6)], 1'b0);
            end
            3: begin
                add_raw(BACKSLASH, 1'b0);
                add_raw(8'($urandom_range(255)), 1'b0);
            end
            4: begin
                add_raw(BACKSLASH, 1'b0);
                add_raw("0", 1'b0);
                n = ($urandom_range(9) < 7) ? 3 : $urandom_range(2);
                for (int k = 0; k < n; k++)
                    add_raw("0" + 8'($urandom_range(7)), 1'b0);
            end
            5: begin
                add_raw(BACKSLASH, 1'b0);
                add_raw("x", 1'b0);
                n = ($urandom_range(9) < 7) ? 2 : $urandom_range(1);
                for (int k = 0; k < n; k++)
                    add_raw(hex_char(4'($urandom_range(15))), 1'b0);
            end
            6, 7: begin
                case ($urandom_range(2))
                    0: code = 16'($urandom_range(16'h007F));
                    1: code = 16'($urandom_range(16'h07FF, 16'h0080));
                    default: code = 16'($urandom_range(16'hFFFF, 16'h0800));
                endcase
                add_raw(BACKSLASH, 1'b0);
                add_raw("u", 1'b0);
                n = ($urandom_range(9) < 7) ? 4 : $urandom_range(3);
                for (int k = 0; k < n; k++)
                    add_raw(hex_char(code[15 - 4 * k -: 4]), 1'b0);
            end
            8: begin
                add_raw(BACKSLASH, 1'b0);
                add_raw($urandom_range(1) ? "U" : BACKSLASH, 1'b0);
            end
            default: add_raw(BACKSLASH, 1'b1);
        endcase
        // end the string here now and then, sometimes in the middle of an escape
        if ($urandom_range(4) == 0) random_bytes[$].fin = 1'b1;
    endfunction

    // ---------------------------------------------------------------- driving

    // Offer one byte, wait for the transaction, then record what it must cause
    task automatic send_byte(input logic [7:0] ch, input logic fin, input logic typed,
                             input dec_result_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        unescape_byte(ch, fin);
        if (typed) begin
            add_due(want);
        end else begin
            foreach (step_out[k]) add_due(step_out[k]);
        end
    endtask

    task automatic send_random_run();
        random_bytes.delete();
        while (random_bytes.size() < RUN_ITEMS) add_sequence();
        foreach (random_bytes[i]) send_byte(random_bytes[i].ch, random_bytes[i].fin, 1'b0, '0);
    endtask

    // Stall the receiver at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : check_results
        dec_result_t got;
        dec_result_t want;
        got = '{data: m_tdata, vld: m_tuser[USER_VALID_BIT], eos: m_tuser[USER_EOS_BIT],
                ovf: m_tuser[USER_OVF_BIT], run_last: m_tlast};
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %h vld %b eos %b ovf %b last %b",
                             got.data, got.vld, got.eos, got.ovf, got.run_last);
            end else begin
                want = due_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected byte %h vld %b eos %b ovf %b last %b",
                                 want.data, want.vld, want.eos, want.ovf, want.run_last);
                        $display("          got      byte %h vld %b eos %b ovf %b last %b",
                                 got.data, got.vld, got.eos, got.ovf, got.run_last);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed strings, then three random runs
    initial begin : stimulus
        foreach (dec_digits[k]) dec_digits[k] = 8'h00;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 55;
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].ch, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].want);
        send_random_run();

        send_idle_pct = 55;
        recv_idle_pct = 7;
        send_random_run();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_run();

        // drain, then keep watching for stray results
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Give up on a hung run
    initial begin : watchdog
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
